### rtl/core/pgg_pkg.sv
// ----------------------------------------------------------------------------
// pgg_pkg
// Shared types and constants for the polar gaussian generator.
// ----------------------------------------------------------------------------
package pgg_pkg;

  localparam int WORD_W  = 32;
  localparam int SUM_W   = 63;
  localparam int SQ_W    = 62;
  localparam int STEP_W  = 5;

  // 2 ln 2 in Q.31
  localparam logic [31:0] TWO_LN2_Q31 = 32'd2977044472;

  // datapath operations, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQA,
    OP_SQB,
    OP_NORM_INIT,
    OP_NORM,
    OP_LOG_INIT,
    OP_LOG,
    OP_TMUL,
    OP_TSUM,
    OP_ROOT,
    OP_ZA,
    OP_ZB,
    OP_SQZA,
    OP_SQZB,
    OP_STAT
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [STEP_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic reject;
    logic norm_done;
  } status_t;

endpackage

### rtl/core/pgg_if.sv
// ----------------------------------------------------------------------------
// pgg_if
// Valid/ready channels for uniform pairs in and normal pairs out.
// ----------------------------------------------------------------------------
interface pgg_in_if;
  logic                         valid;
  logic                         ready;
  logic [pgg_pkg::WORD_W-1:0]   uniform_a;
  logic [pgg_pkg::WORD_W-1:0]   uniform_b;
  logic                         clear_stats;

  modport source (output valid, uniform_a, uniform_b, clear_stats, input ready);
  modport sink   (input valid, uniform_a, uniform_b, clear_stats, output ready);
endinterface

interface pgg_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [pgg_pkg::WORD_W-1:0] normal_a;
  logic signed [pgg_pkg::WORD_W-1:0] normal_b;
  logic [pgg_pkg::WORD_W-1:0]        normals_made;
  logic signed [pgg_pkg::SUM_W-1:0]  sum_normals;
  logic [pgg_pkg::SQ_W-1:0]          sum_squares;

  modport source (output valid, normal_a, normal_b, normals_made, sum_normals, sum_squares,
                  input ready);
  modport sink   (input valid, normal_a, normal_b, normals_made, sum_normals, sum_squares,
                  output ready);
endinterface

### rtl/core/pgg_datapath.sv
// ----------------------------------------------------------------------------
// pgg_datapath
// Registers, shared 32x32 multiplier, square root and divide steps.
// ----------------------------------------------------------------------------
module pgg_datapath #(
  parameter int UNIFORM_BITS  = 32,
  parameter int OUT_FRAC_BITS = 27
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  pgg_pkg::cmd_t                      cmd,
  output pgg_pkg::status_t                   status,
  input  logic [pgg_pkg::WORD_W-1:0]         in_uniform_a,
  input  logic [pgg_pkg::WORD_W-1:0]         in_uniform_b,
  input  logic                               in_clear_stats,
  output logic signed [pgg_pkg::WORD_W-1:0]  out_normal_a,
  output logic signed [pgg_pkg::WORD_W-1:0]  out_normal_b,
  output logic [pgg_pkg::WORD_W-1:0]         out_normals_made,
  output logic signed [pgg_pkg::SUM_W-1:0]   out_sum_normals,
  output logic [pgg_pkg::SQ_W-1:0]           out_sum_squares
);
  import pgg_pkg::*;

  localparam int LW = 2 * UNIFORM_BITS - 2;
  localparam int SH = 59 - OUT_FRAC_BITS;
  localparam logic [31:0] HALF     = 32'(64'(1) << (UNIFORM_BITS - 1));
  localparam logic [63:0] S_LIMIT  = 64'(1) << LW;
  localparam logic [63:0] N_LIMIT  = 64'(1) << 60;
  localparam logic [63:0] Z_ROUND  = 64'(1) << (SH - 1);
  localparam logic [63:0] SQ_ROUND = 64'(1) << (OUT_FRAC_BITS - 1);
  localparam logic signed [64:0] SUM_MAX = 65'sd4611686018427387903;
  localparam logic signed [64:0] SUM_MIN = -65'sd4611686018427387904;
  localparam logic [63:0] SQ_MAX = 64'h3FFF_FFFF_FFFF_FFFF;

  logic [31:0] ma_r, mb_r;
  logic        neg_a_r, neg_b_r;
  logic [63:0] s_r, sn_r;
  logic [4:0]  k_r;
  logic [5:0]  p_r;
  logic [31:0] m_r, frac_r;
  logic [63:0] x_r, root_r;
  logic [31:0] d_r;
  logic [63:0] tlo_r;
  logic [37:0] thi_r;
  logic [31:0] rema_r, numa_r, remb_r, numb_r;
  logic signed [31:0] za_r, zb_r;
  logic [31:0] zmag_a_r, zmag_b_r;
  logic [63:0] sqa_r, sqb_r;
  logic [31:0] count_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [SQ_W-1:0] sqsum_r;
  logic signed [31:0] o_na_r, o_nb_r;
  logic [31:0] o_cnt_r;
  logic signed [SUM_W-1:0] o_sum_r;
  logic [SQ_W-1:0] o_sq_r;
  logic [63:0] nl2;

  // shared multiplier operand select
  logic [31:0] mul_x, mul_y;
  logic [63:0] mul_p;
  always_comb begin
    mul_x = m_r;
    mul_y = m_r;
    case (cmd.op)
      OP_SQA:  begin mul_x = ma_r;     mul_y = ma_r;        end
      OP_SQB:  begin mul_x = mb_r;     mul_y = mb_r;        end
      OP_TMUL: begin mul_x = nl2[31:0]; mul_y = TWO_LN2_Q31; end
      OP_ZA:   begin mul_x = numa_r;   mul_y = root_r[31:0]; end
      OP_ZB:   begin mul_x = numb_r;   mul_y = root_r[31:0]; end
      OP_SQZA: begin mul_x = zmag_a_r; mul_y = zmag_a_r;    end
      OP_SQZB: begin mul_x = zmag_b_r; mul_y = zmag_b_r;    end
      default: begin mul_x = m_r;      mul_y = m_r;         end
    endcase
  end
  assign mul_p = 64'(mul_x) * 64'(mul_y);

  // input mapping v = u - half
  logic [31:0] ua, ub;
  assign ua = 32'(in_uniform_a[UNIFORM_BITS-1:0]);
  assign ub = 32'(in_uniform_b[UNIFORM_BITS-1:0]);

  // log setup from the normalized radius
  logic [1:0]  lead_e;
  logic [63:0] n_val;
  always_comb begin
    if (sn_r[62])      lead_e = 2'd0;
    else if (sn_r[61]) lead_e = 2'd1;
    else               lead_e = 2'd2;
    n_val = sn_r << lead_e;
    nl2   = {32'(LW) - 32'(p_r), 32'd0} - {32'd0, frac_r};
  end

  // square root step
  logic [63:0] sq_b, sq_rb;
  logic        sq_ge;
  assign sq_b  = 64'(1) << (6'd62 - {cmd.step, 1'b0});
  assign sq_rb = root_r + sq_b;
  assign sq_ge = x_r >= sq_rb;

  // restoring divide steps, one quotient bit each
  logic [32:0] tra, trb;
  logic        gea, geb;
  assign tra = {rema_r, numa_r[31]};
  assign trb = {remb_r, numb_r[31]};
  assign gea = tra >= {1'b0, d_r};
  assign geb = trb >= {1'b0, d_r};

  // log round
  logic [32:0] mm;
  assign mm = mul_p[63:31];

  // t and divider numerators
  logic [63:0] t_val, na, nb;
  assign t_val = {25'd0, thi_r, 1'b0} + (tlo_r >> 31);
  assign na    = 64'(ma_r) << (6'(k_r) + 6'd31);
  assign nb    = 64'(mb_r) << (6'(k_r) + 6'd31);

  // rounded magnitude and saturation of z
  logic [63:0] zmag;
  logic        zneg;
  logic signed [31:0] zsat;
  logic [31:0] zsat_mag;
  always_comb begin
    zmag = (mul_p + Z_ROUND) >> SH;
    zneg = (cmd.op == OP_ZA) ? neg_a_r : neg_b_r;
    if (zneg) begin
      if (zmag > 64'h8000_0000) begin
        zsat_mag = 32'h8000_0000;
      end else begin
        zsat_mag = zmag[31:0];
      end
      zsat = -$signed(zsat_mag);
    end else begin
      if (zmag > 64'h7FFF_FFFF) begin
        zsat_mag = 32'h7FFF_FFFF;
      end else begin
        zsat_mag = zmag[31:0];
      end
      zsat = $signed(zsat_mag);
    end
  end

  // statistics update
  logic [63:0] sqz, sq_tot;
  logic signed [64:0] sum_tot;
  logic signed [SUM_W-1:0] sum_nxt;
  logic [SQ_W-1:0] sqsum_nxt;
  logic [31:0] count_nxt;
  always_comb begin
    sqz     = (mul_p + SQ_ROUND) >> OUT_FRAC_BITS;
    sum_tot = 65'(sum_r) + 65'(za_r) + 65'(zb_r);
    if (sum_tot > SUM_MAX)      sum_nxt = SUM_MAX[SUM_W-1:0];
    else if (sum_tot < SUM_MIN) sum_nxt = SUM_MIN[SUM_W-1:0];
    else                        sum_nxt = sum_tot[SUM_W-1:0];
    sq_tot = 64'(sqsum_r) + sqa_r + sqb_r;
    sqsum_nxt = (sq_tot > SQ_MAX) ? SQ_MAX[SQ_W-1:0] : sq_tot[SQ_W-1:0];
    count_nxt = (count_r >= 32'hFFFF_FFFD) ? 32'hFFFF_FFFF : count_r + 32'd2;
  end

  assign status.reject    = (s_r == 64'd0) || (s_r > S_LIMIT);
  assign status.norm_done = sn_r > N_LIMIT;

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        neg_a_r <= ua < HALF;
        neg_b_r <= ub < HALF;
        ma_r    <= (ua < HALF) ? HALF - ua : ua - HALF;
        mb_r    <= (ub < HALF) ? HALF - ub : ub - HALF;
      end
      OP_SQA: s_r <= mul_p;
      OP_SQB: s_r <= s_r + mul_p;
      OP_NORM_INIT: begin
        sn_r <= s_r;
        k_r  <= '0;
      end
      OP_NORM: begin
        sn_r <= sn_r << 2;
        k_r  <= k_r + 5'd1;
      end
      OP_LOG_INIT: begin
        m_r    <= n_val[62:31];
        p_r    <= 6'd62 - {k_r, 1'b0} - 6'(lead_e);
        frac_r <= '0;
        x_r    <= sn_r;
        root_r <= '0;
      end
      OP_LOG: begin
        if (mm[32]) begin
          m_r    <= mm[32:1];
          frac_r <= {frac_r[30:0], 1'b1};
        end else begin
          m_r    <= mm[31:0];
          frac_r <= {frac_r[30:0], 1'b0};
        end
        if (sq_ge) begin
          x_r    <= x_r - sq_rb;
          root_r <= (root_r >> 1) + sq_b;
        end else begin
          root_r <= root_r >> 1;
        end
      end
      OP_TMUL: begin
        tlo_r <= mul_p;
        thi_r <= 38'(nl2[37:32]) * 38'(TWO_LN2_Q31);
        d_r   <= root_r[31:0];
      end
      OP_TSUM: begin
        x_r    <= {t_val[39:8], 32'd0};
        root_r <= '0;
        rema_r <= na[63:32];
        numa_r <= na[31:0];
        remb_r <= nb[63:32];
        numb_r <= nb[31:0];
      end
      OP_ROOT: begin
        if (sq_ge) begin
          x_r    <= x_r - sq_rb;
          root_r <= (root_r >> 1) + sq_b;
        end else begin
          root_r <= root_r >> 1;
        end
        rema_r <= gea ? 32'(tra - {1'b0, d_r}) : tra[31:0];
        numa_r <= {numa_r[30:0], gea};
        remb_r <= geb ? 32'(trb - {1'b0, d_r}) : trb[31:0];
        numb_r <= {numb_r[30:0], geb};
      end
      OP_ZA: begin
        za_r     <= zsat;
        zmag_a_r <= zsat_mag;
      end
      OP_ZB: begin
        zb_r     <= zsat;
        zmag_b_r <= zsat_mag;
      end
      OP_SQZA: sqa_r <= sqz;
      OP_SQZB: sqb_r <= sqz;
      OP_STAT: begin
        o_na_r  <= za_r;
        o_nb_r  <= zb_r;
        o_cnt_r <= count_nxt;
        o_sum_r <= sum_nxt;
        o_sq_r  <= sqsum_nxt;
      end
      default: begin
      end
    endcase
  end

  // running statistics
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
      sqsum_r <= '0;
    end else if (cmd.op == OP_LOAD && in_clear_stats) begin
      count_r <= '0;
      sum_r   <= '0;
      sqsum_r <= '0;
    end else if (cmd.op == OP_STAT) begin
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      sqsum_r <= sqsum_nxt;
    end
  end

  assign out_normal_a     = o_na_r;
  assign out_normal_b     = o_nb_r;
  assign out_normals_made = o_cnt_r;
  assign out_sum_normals  = o_sum_r;
  assign out_sum_squares  = o_sq_r;

endmodule

### rtl/core/pgg_ctrl.sv
// ----------------------------------------------------------------------------
// pgg_ctrl
// Sequencer for the polar method: issues one datapath operation per cycle unless idle or stalled.
// ----------------------------------------------------------------------------
module pgg_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  pgg_pkg::status_t status,
  output pgg_pkg::cmd_t    cmd
);
  import pgg_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_SQA   = 14'b00000000000010,
    S_SQB   = 14'b00000000000100,
    S_CHECK = 14'b00000000001000,
    S_NORM  = 14'b00000000010000,
    S_LOG   = 14'b00000000100000,
    S_TMUL  = 14'b00000001000000,
    S_TSUM  = 14'b00000010000000,
    S_ROOT  = 14'b00000100000000,
    S_ZA    = 14'b00001000000000,
    S_ZB    = 14'b00010000000000,
    S_SQZA  = 14'b00100000000000,
    S_SQZB  = 14'b01000000000000,
    S_STAT  = 14'b10000000000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

  // next state and operation
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd.op        = OP_NONE;
    cmd.step      = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_SQA;
        end
      end
      S_SQA: begin
        cmd.op    = OP_SQA;
        state_nxt = S_SQB;
      end
      S_SQB: begin
        cmd.op    = OP_SQB;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.op    = OP_NORM_INIT;
        state_nxt = status.reject ? S_IDLE : S_NORM;
      end
      S_NORM: begin
        if (status.norm_done) begin
          cmd.op    = OP_LOG_INIT;
          cnt_nxt   = '0;
          state_nxt = S_LOG;
        end else begin
          cmd.op = OP_NORM;
        end
      end
      S_LOG: begin
        cmd.op  = OP_LOG;
        cnt_nxt = cnt_r + STEP_W'(1);
        if (&cnt_r) state_nxt = S_TMUL;
      end
      S_TMUL: begin
        cmd.op    = OP_TMUL;
        state_nxt = S_TSUM;
      end
      S_TSUM: begin
        cmd.op    = OP_TSUM;
        cnt_nxt   = '0;
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        cmd.op  = OP_ROOT;
        cnt_nxt = cnt_r + STEP_W'(1);
        if (&cnt_r) state_nxt = S_ZA;
      end
      S_ZA: begin
        cmd.op    = OP_ZA;
        state_nxt = S_ZB;
      end
      S_ZB: begin
        cmd.op    = OP_ZB;
        state_nxt = S_SQZA;
      end
      S_SQZA: begin
        cmd.op    = OP_SQZA;
        state_nxt = S_SQZB;
      end
      S_SQZB: begin
        cmd.op    = OP_SQZB;
        state_nxt = S_STAT;
      end
      S_STAT: begin
        // result register must be free before the stats move
        if (slot_free) begin
          cmd.op        = OP_STAT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/core/polar_gaussian_generator.sv
// ----------------------------------------------------------------------------
// polar_gaussian_generator
// Marsaglia polar gaussian generator with running statistics.
// ----------------------------------------------------------------------------
// in_ch takes a word of two uniform fractions and a clear bit; out_ch gives
// a word of two normals in Q4.27 with the count, sum and sum of squares after
// the pair. A pair with w > 1 or w == 0 gives no word (a clear still acts).
// One pair is worked on at a time. An accepted pair runs through the
// 2-bit-per-cycle normalize loop, the 32-round log loop that runs beside the
// first 32-step square root, and the second square root that runs beside the
// two 32-step dividers. A rejected pair frees the input at the check that
// follows the two squares.
// The result sits in an output register; the next pair is taken while it
// waits, and a stalled receiver only holds the next pair at its final step.
// Reset (rst_n low, synchronous) clears the sequencer, the output valid and
// the statistics.
// ----------------------------------------------------------------------------
module polar_gaussian_generator #(
  parameter int UNIFORM_BITS  = 32,
  parameter int OUT_FRAC_BITS = 27
) (
  input  logic      clk,
  input  logic      rst_n,
  pgg_in_if.sink    in_ch,
  pgg_out_if.source out_ch
);
  import pgg_pkg::*;

  cmd_t    cmd;
  status_t status;

  pgg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  pgg_datapath #(
    .UNIFORM_BITS  (UNIFORM_BITS),
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_uniform_a     (in_ch.uniform_a),
    .in_uniform_b     (in_ch.uniform_b),
    .in_clear_stats   (in_ch.clear_stats),
    .out_normal_a     (out_ch.normal_a),
    .out_normal_b     (out_ch.normal_b),
    .out_normals_made (out_ch.normals_made),
    .out_sum_normals  (out_ch.sum_normals),
    .out_sum_squares  (out_ch.sum_squares)
  );

endmodule

### verif/polar_gaussian_generator_tb.sv
// ----------------------------------------------------------------------------
// polar_gaussian_generator_tb
// Drives uniform pairs into the polar gaussian generator, predicts each word
// of normals and statistics with an exact fixed-point model of the polar
// method, and checks every result word field by field.
// ----------------------------------------------------------------------------
module polar_gaussian_generator_tb;
  import pgg_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam longint HALF_RANGE = 64'sh8000_0000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   idle_cycles;

  typedef struct {
    logic signed [WORD_W-1:0] normal_a;
    logic signed [WORD_W-1:0] normal_b;
    logic [WORD_W-1:0]        normals_made;
    logic signed [SUM_W-1:0]  sum_normals;
    logic [SQ_W-1:0]          sum_squares;
  } normal_word_t;

  pgg_in_if  in_ch ();
  pgg_out_if out_ch ();

  polar_gaussian_generator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // mismatch report
  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    fail_count++;
  endtask

  // gaussian predictor and queue of pending normal words
  class normal_scoreboard;
    logic signed [SUM_W-1:0] stat_sum;
    logic [SQ_W-1:0]         stat_sq;
    logic [WORD_W-1:0]       stat_count;
    normal_word_t            pending[$];

    function new();
      stat_sum = '0;
      stat_sq = '0;
      stat_count = '0;
    endfunction

    static function logic [63:0] int_sqrt(input logic [63:0] x);
      logic [63:0] r, b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // sqrt(-2 ln w) in Q.28 for w = s / 2^62
    static function logic [63:0] radius_root(input logic [63:0] s);
      int p;
      logic [63:0] m, frac, nl2, hi, lo, t;
      p = 0;
      while (p < 63 && (s >> (p + 1)) != 0) p++;
      m = (p >= 31) ? (s >> (p - 31)) : (s << (31 - p));
      frac = 0;
      for (int i = 0; i < 32; i++) begin
        m = (m * m) >> 31;
        frac = frac << 1;
        if (m >= 64'h1_0000_0000) begin
          frac = frac | 1;
          m = m >> 1;
        end
      end
      nl2 = ({32'd0, 32'(62 - p)} << 32) - frac;
      hi = nl2 >> 32;
      lo = nl2 & 64'hFFFF_FFFF;
      t = ((hi * TWO_LN2_Q31) << 1) + ((lo * TWO_LN2_Q31) >> 31);
      return int_sqrt((t >> 8) << 32);
    endfunction

    static function logic signed [63:0] scale_normal(input logic [63:0] mag_v, input bit neg,
                                                     input int k, input logic [63:0] d,
                                                     input logic [63:0] r);
      logic [63:0] c, mag;
      c = ((mag_v << k) << 31) / d;
      mag = (c * r + (64'd1 << 31)) >> 32;
      if (neg) return (mag > 64'h8000_0000) ? -64'sh8000_0000 : -$signed(mag);
      return (mag > 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : $signed(mag);
    endfunction

    static function logic [63:0] square_q27(input logic signed [63:0] z);
      logic [63:0] m;
      m = (z < 0) ? -z : z;
      return (m * m + (64'd1 << 26)) >> 27;
    endfunction

    // note an accepted pair, queue its word if the pair is kept
    function void note_pair(input logic [31:0] ua, input logic [31:0] ub, input bit clr);
      logic signed [63:0] va, vb, za, zb;
      logic [63:0] ma, mb, s, sn, d, r, sq;
      logic signed [64:0] sum;
      int k;
      normal_word_t w;
      if (clr) begin
        stat_sum = '0;
        stat_sq = '0;
        stat_count = '0;
      end
      va = $signed({32'd0, ua}) - HALF_RANGE;
      vb = $signed({32'd0, ub}) - HALF_RANGE;
      ma = (va < 0) ? -va : va;
      mb = (vb < 0) ? -vb : vb;
      s = ma * ma + mb * mb;
      if (s == 0 || s > (64'd1 << 62)) return;
      r = radius_root(s);
      sn = s;
      k = 0;
      while (sn <= (64'd1 << 60)) begin
        sn = sn << 2;
        k++;
      end
      d = int_sqrt(sn);
      za = scale_normal(ma, va < 0, k, d, r);
      zb = scale_normal(mb, vb < 0, k, d, r);
      stat_count = (stat_count >= 32'hFFFF_FFFD) ? 32'hFFFF_FFFF : stat_count + 2;
      sum = 65'(stat_sum) + za + zb;
      if (sum > 65'sh3FFF_FFFF_FFFF_FFFF) stat_sum = 63'sh3FFF_FFFF_FFFF_FFFF;
      else if (sum < -65'sh4000_0000_0000_0000) stat_sum = 63'sh4000_0000_0000_0000;
      else stat_sum = sum[SUM_W-1:0];
      sq = {2'b00, stat_sq} + square_q27(za) + square_q27(zb);
      stat_sq = (sq > 64'h3FFF_FFFF_FFFF_FFFF) ? 62'h3FFF_FFFF_FFFF_FFFF : sq[SQ_W-1:0];
      w.normal_a = za[31:0];
      w.normal_b = zb[31:0];
      w.normals_made = stat_count;
      w.sum_normals = stat_sum;
      w.sum_squares = stat_sq;
      pending.push_back(w);
    endfunction

    // compare an accepted word with the oldest expectation
    task check_word(input normal_word_t got);
      normal_word_t exp_w;
      if (pending.size() == 0) begin
        report_mismatch("result word with nothing expected");
        return;
      end
      exp_w = pending.pop_front();
      if (got.normal_a !== exp_w.normal_a)
        report_mismatch($sformatf("normal_a %0d exp %0d", got.normal_a, exp_w.normal_a));
      if (got.normal_b !== exp_w.normal_b)
        report_mismatch($sformatf("normal_b %0d exp %0d", got.normal_b, exp_w.normal_b));
      if (got.normals_made !== exp_w.normals_made)
        report_mismatch($sformatf("normals_made %0d exp %0d", got.normals_made,
                                  exp_w.normals_made));
      if (got.sum_normals !== exp_w.sum_normals)
        report_mismatch($sformatf("sum_normals %0d exp %0d", got.sum_normals,
                                  exp_w.sum_normals));
      if (got.sum_squares !== exp_w.sum_squares)
        report_mismatch($sformatf("sum_squares %0d exp %0d", got.sum_squares,
                                  exp_w.sum_squares));
    endtask
  endclass

  normal_scoreboard board;
  bit idle_off;

  // clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // watchdog on cycles with no accepted word
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("polar_gaussian_generator_tb NOT OK");
        $finish;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    normal_word_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.normal_a = out_ch.normal_a;
      got.normal_b = out_ch.normal_b;
      got.normals_made = out_ch.normals_made;
      got.sum_normals = out_ch.sum_normals;
      got.sum_squares = out_ch.sum_squares;
      board.check_word(got);
    end
  end

  // receiver with random stall bursts
  initial begin
    int burst;
    out_ch.ready = 0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if (!idle_off && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 12);
        out_ch.ready <= 0;
        repeat (burst) @(negedge clk);
      end else begin
        out_ch.ready <= 1;
        @(negedge clk);
      end
    end
  end

  // send one pair, held until taken
  task automatic send_pair(input logic [31:0] ua, input logic [31:0] ub, input bit clr);
    int burst;
    if (!idle_off && $urandom_range(0, 3) == 0) begin
      burst = $urandom_range(1, 12);
      in_ch.valid <= 0;
      repeat (burst) @(negedge clk);
    end
    in_ch.valid <= 1;
    in_ch.uniform_a <= ua;
    in_ch.uniform_b <= ub;
    in_ch.clear_stats <= clr;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_pair(ua, ub, clr);
    @(negedge clk);
  endtask

  // random pair, mostly inside the unit circle
  task automatic send_random(input int mode);
    logic [31:0] ua, ub;
    int r;
    r = $urandom_range(0, 9);
    ua = $urandom;
    ub = $urandom;
    if (r < 7) begin
      // keep v inside the disk by bounding both magnitudes below 1/sqrt(2)
      ua = 32'h8000_0000 + $signed($urandom_range(0, 32'h5A82_7990)) *
           ($urandom_range(0, 1) ? 1 : -1);
      ub = 32'h8000_0000 + $signed($urandom_range(0, 32'h5A82_7990)) *
           ($urandom_range(0, 1) ? 1 : -1);
    end else if (r == 7) begin
      // near the center, tiny radius
      ua = 32'h8000_0000 + $urandom_range(0, 64) - 32;
      ub = 32'h8000_0000 + $urandom_range(0, 64) - 32;
    end
    send_pair(ua, ub, (mode == 1) || ($urandom_range(0, 99) == 0));
  endtask

  initial begin
    board = new();
    fail_count = 0;
    idle_cycles = 0;
    idle_off = 0;
    rst_n = 0;
    in_ch.valid = 0;
    in_ch.uniform_a = '0;
    in_ch.uniform_b = '0;
    in_ch.clear_stats = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: center (zero radius), unit radius, corners, extremes
    send_pair(32'h8000_0000, 32'h8000_0000, 0);
    send_pair(32'h0000_0000, 32'h8000_0000, 0);
    send_pair(32'h8000_0000, 32'h0000_0000, 0);
    send_pair(32'h0000_0000, 32'h0000_0000, 0);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_pair(32'hFFFF_FFFF, 32'h8000_0000, 0);
    send_pair(32'h8000_0000, 32'hFFFF_FFFF, 1);
    send_pair(32'h8000_0001, 32'h8000_0000, 0);
    send_pair(32'h7FFF_FFFF, 32'h8000_0000, 0);
    send_pair(32'h8000_0001, 32'h8000_0001, 0);
    send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
    send_pair(32'hC000_0000, 32'h4000_0000, 0);
    send_pair(32'h5555_5555, 32'hAAAA_AAAA, 0);
    send_pair(32'hAAAA_AAAA, 32'h5555_5555, 1);
    send_pair(32'h0000_0001, 32'h8000_0000, 0);
    send_pair(32'hDA82_7999, 32'hDA82_7999, 0);

    // hold off until every word is back
    in_ch.valid <= 0;
    while (board.pending.size() != 0) @(negedge clk);

    for (int i = 0; i < 1200; i++) begin
      if (i == 600) begin
        in_ch.valid <= 0;
        while (board.pending.size() != 0) @(negedge clk);
        send_random(1);
      end else begin
        if (i == 1000) idle_off = 1;
        send_random(0);
      end
    end
    in_ch.valid <= 0;

    while (board.pending.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fail_count == 0) begin
      $display("polar_gaussian_generator_tb OK");
    end else begin
      $display("polar_gaussian_generator_tb NOT OK");
    end
    $finish;
  end
endmodule

### polar_gaussian_generator.f
rtl/core/pgg_pkg.sv
rtl/core/pgg_if.sv
rtl/core/pgg_datapath.sv
rtl/core/pgg_ctrl.sv
rtl/core/polar_gaussian_generator.sv
verif/polar_gaussian_generator_tb.sv
